### rtl/pbl_pkg.sv
package pbl_pkg;

  localparam int COORD_W    = 32;
  localparam int BOX_IDX_W  = 12;
  localparam int BOX_CNT_W  = 13;
  localparam int HIT_IDX_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GMIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GMIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GMIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GMAX_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GMAX_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GMAX_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_COUNT = 3'd6;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x_min;
    coord_t x_max;
    coord_t y_min;
    coord_t y_max;
    coord_t z_min;
    coord_t z_max;
  } box_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCHK,
    ST_SCAN,
    ST_DONE
  } pbl_state_t;

  typedef enum logic [1:0] {
    RK_OUTSIDE,
    RK_HIT,
    RK_MISS
  } res_kind_t;

  typedef struct packed {
    logic      in_ready;
    logic      take_point;
    logic      load_box;
    logic      scan_read;
    logic      set_res;
    res_kind_t res_kind;
    logic      emit;
  } pbl_cmd_t;

  typedef struct packed {
    logic glob_pass;
    logic cnt_zero;
    logic match;
    logic scan_end;
    logic out_free;
  } pbl_status_t;

endpackage

### rtl/pbl_ifs.sv
interface pbl_in_if;
  import pbl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [BOX_IDX_W-1:0] box_index;
  coord_t               box_x_min;
  coord_t               box_x_max;
  coord_t               box_y_min;
  coord_t               box_y_max;
  coord_t               box_z_min;
  coord_t               box_z_max;
  coord_t               point_x;
  coord_t               point_y;
  coord_t               point_z;

  modport source (
    output valid, req_type, box_index, box_x_min, box_x_max, box_y_min, box_y_max,
           box_z_min, box_z_max, point_x, point_y, point_z,
    input  ready
  );

  modport sink (
    input  valid, req_type, box_index, box_x_min, box_x_max, box_y_min, box_y_max,
           box_z_min, box_z_max, point_x, point_y, point_z,
    output ready
  );
endinterface

interface pbl_out_if;
  import pbl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 inside_res;
  logic [HIT_IDX_W-1:0] hit_index;
  logic                 outside_global;

  modport source (
    output valid, inside_res, hit_index, outside_global,
    input  ready
  );

  modport sink (
    input  valid, inside_res, hit_index, outside_global,
    output ready
  );
endinterface

### rtl/pbl_ram.sv
module pbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/pbl_dp.sv
module pbl_dp #(
  parameter int MAX_BOXES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pbl_in_if.sink                        in_bus,
  pbl_out_if.source                     out_bus,
  input  logic                          cfg_we,
  input  logic [pbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  pbl_pkg::pbl_cmd_t             cmd,
  output pbl_pkg::pbl_status_t          status
);
  import pbl_pkg::*;

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int NW = (CW > BOX_CNT_W) ? CW : BOX_CNT_W;
  localparam int SW = (AW + 1 > BOX_IDX_W) ? AW + 1 : BOX_IDX_W + 1;

  // global bounds and count
  coord_t               gmin_x_r, gmin_y_r, gmin_z_r;
  coord_t               gmax_x_r, gmax_y_r, gmax_z_r;
  logic [BOX_CNT_W-1:0] box_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gmin_x_r    <= '0;
      gmin_y_r    <= '0;
      gmin_z_r    <= '0;
      gmax_x_r    <= '0;
      gmax_y_r    <= '0;
      gmax_z_r    <= '0;
      box_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GMIN_X:    gmin_x_r    <= coord_t'(cfg_wdata[COORD_W-1:0]);
        CFG_GMIN_Y:    gmin_y_r    <= coord_t'(cfg_wdata[COORD_W-1:0]);
        CFG_GMIN_Z:    gmin_z_r    <= coord_t'(cfg_wdata[COORD_W-1:0]);
        CFG_GMAX_X:    gmax_x_r    <= coord_t'(cfg_wdata[COORD_W-1:0]);
        CFG_GMAX_Y:    gmax_y_r    <= coord_t'(cfg_wdata[COORD_W-1:0]);
        CFG_GMAX_Z:    gmax_z_r    <= coord_t'(cfg_wdata[COORD_W-1:0]);
        CFG_BOX_COUNT: box_count_r <= cfg_wdata[BOX_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // box store write side
  logic [SW-1:0]           slot_ext;
  logic                    slot_ok;
  logic [AW+BOX_IDX_W-1:0] waddr_ext;
  box_t                    wbox;

  assign slot_ext  = SW'(in_bus.box_index);
  assign slot_ok   = slot_ext < SW'(MAX_BOXES);
  assign waddr_ext = {{AW{1'b0}}, in_bus.box_index};
  assign wbox      = '{x_min: in_bus.box_x_min, x_max: in_bus.box_x_max,
                       y_min: in_bus.box_y_min, y_max: in_bus.box_y_max,
                       z_min: in_bus.box_z_min, z_max: in_bus.box_z_max};

  // query point and scan state
  coord_t         px_r, py_r, pz_r;
  logic [CW-1:0]  n_r, n_nxt;
  logic [CW-1:0]  cnt_r;
  logic [AW-1:0]  pidx_r;
  logic [NW-1:0]  cnt_ext, cap, n_sat;
  box_t           rbox;

  assign cnt_ext = NW'(box_count_r);
  assign cap     = NW'(MAX_BOXES);
  assign n_sat   = (cnt_ext > cap) ? cap : cnt_ext;
  assign n_nxt   = n_sat[CW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.take_point) begin
      px_r  <= in_bus.point_x;
      py_r  <= in_bus.point_y;
      pz_r  <= in_bus.point_z;
      n_r   <= n_nxt;
      cnt_r <= '0;
    end else if (cmd.scan_read) begin
      cnt_r  <= cnt_r + CW'(1);
      pidx_r <= cnt_r[AW-1:0];
    end
  end

  pbl_ram #(
    .WIDTH ($bits(box_t)),
    .DEPTH (MAX_BOXES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_box && slot_ok),
    .waddr (waddr_ext[AW-1:0]),
    .wdata (wbox),
    .re    (cmd.scan_read),
    .raddr (cnt_r[AW-1:0]),
    .rdata (rbox)
  );

  // result holding and output register
  logic                    res_inside_r, res_outside_r;
  logic [HIT_IDX_W-1:0]    res_idx_r;
  logic [AW+HIT_IDX_W-1:0] hit_ext;
  logic                    out_valid_r;
  logic                    out_inside_r, out_outside_r;
  logic [HIT_IDX_W-1:0]    out_idx_r;

  assign hit_ext = {{HIT_IDX_W{1'b0}}, pidx_r};

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      case (cmd.res_kind)
        RK_OUTSIDE: begin
          res_inside_r  <= 1'b0;
          res_outside_r <= 1'b1;
          res_idx_r     <= '0;
        end
        RK_HIT: begin
          res_inside_r  <= 1'b1;
          res_outside_r <= 1'b0;
          res_idx_r     <= hit_ext[HIT_IDX_W-1:0];
        end
        default: begin
          res_inside_r  <= 1'b0;
          res_outside_r <= 1'b0;
          res_idx_r     <= '0;
        end
      endcase
    end
    if (cmd.emit) begin
      out_inside_r  <= res_inside_r;
      out_outside_r <= res_outside_r;
      out_idx_r     <= res_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.inside_res     = out_inside_r;
  assign out_bus.hit_index      = out_idx_r;
  assign out_bus.outside_global = out_outside_r;
  assign in_bus.ready           = cmd.in_ready;

  // status back to the controller
  assign status.glob_pass = (px_r >= gmin_x_r) && (px_r <= gmax_x_r) &&
                            (py_r >= gmin_y_r) && (py_r <= gmax_y_r) &&
                            (pz_r >= gmin_z_r) && (pz_r <= gmax_z_r);
  assign status.cnt_zero  = (n_r == '0);
  assign status.match     = (px_r >= rbox.x_min) && (px_r <= rbox.x_max) &&
                            (py_r >= rbox.y_min) && (py_r <= rbox.y_max) &&
                            (pz_r >= rbox.z_min) && (pz_r <= rbox.z_max);
  assign status.scan_end  = (cnt_r == n_r);
  assign status.out_free  = !out_valid_r || out_bus.ready;

endmodule

### rtl/pbl_ctrl.sv
module pbl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_query,
  input  pbl_pkg::pbl_status_t status,
  output pbl_pkg::pbl_cmd_t    cmd
);
  import pbl_pkg::*;

  pbl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_kind = RK_MISS;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          if (in_query) begin
            cmd.take_point = 1'b1;
            state_nxt      = ST_GCHK;
          end else begin
            cmd.load_box = 1'b1;
          end
        end
      end
      ST_GCHK: begin
        if (!status.glob_pass) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RK_OUTSIDE;
          state_nxt    = ST_DONE;
        end else if (status.cnt_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RK_MISS;
          state_nxt    = ST_DONE;
        end else begin
          cmd.scan_read = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read data always belongs to the previously issued slot
        if (status.match) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RK_HIT;
          state_nxt    = ST_DONE;
        end else if (status.scan_end) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RK_MISS;
          state_nxt    = ST_DONE;
        end else begin
          cmd.scan_read = 1'b1;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/point_in_box_list_test.sv
// load beat: taken in ST_IDLE with no result; the next beat is taken the cycle after
// query: the point is registered on accept, ST_GCHK rejects it by the global box or a count of 0,
// else ST_SCAN reads boxes in order up to the first hit or the last box; ST_DONE then waits for the output
// one stored box is read per cycle from the single-read-port box store; one query at a time
// reset clears the controller, output valid and the configuration registers to 0;
// box store contents are undefined until loaded, no clearing pass
module point_in_box_list_test #(
  parameter int MAX_BOXES = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pbl_in_if.sink                         in_bus,
  pbl_out_if.source                      out_bus,
  input  logic                           cfg_we,
  input  logic [pbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pbl_pkg::*;

  pbl_cmd_t    cmd;
  pbl_status_t status;

  pbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_query (in_bus.req_type == REQ_QUERY),
    .status   (status),
    .cmd      (cmd)
  );

  pbl_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

### bench/box_hit_checker.sv
module box_hit_checker #(
  parameter int MAX_BOXES = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pbl_in_if                              in_bus,
  pbl_out_if                             out_bus,
  input  logic                           cfg_we,
  input  logic [pbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             answers_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import pbl_pkg::*;

  typedef struct packed {
    logic                 in_box;
    logic [HIT_IDX_W-1:0] hit;
    logic                 outside;
    coord_t               px;
    coord_t               py;
    coord_t               pz;
  } answer_t;

  answer_t              hit_answers [$];
  answer_t              want;
  box_t                 box_mirror [MAX_BOXES];
  coord_t               win_lo [3];
  coord_t               win_hi [3];
  logic [BOX_CNT_W-1:0] box_limit;

  function automatic bit between(coord_t lo, coord_t p, coord_t hi);
    return ($signed(lo) <= $signed(p)) && ($signed(p) <= $signed(hi));
  endfunction

  // global window first, then the first stored box that holds the point
  function automatic answer_t first_hit(coord_t px, coord_t py, coord_t pz);
    answer_t a;
    int      n;
    a = '0;
    a.px = px;
    a.py = py;
    a.pz = pz;
    if (!between(win_lo[0], px, win_hi[0]) || !between(win_lo[1], py, win_hi[1]) ||
        !between(win_lo[2], pz, win_hi[2])) begin
      a.outside = 1'b1;
      return a;
    end
    n = (box_limit > MAX_BOXES) ? MAX_BOXES : int'(box_limit);
    for (int i = 0; i < n; i++) begin
      if (between(box_mirror[i].x_min, px, box_mirror[i].x_max) &&
          between(box_mirror[i].y_min, py, box_mirror[i].y_max) &&
          between(box_mirror[i].z_min, pz, box_mirror[i].z_max)) begin
        a.in_box = 1'b1;
        a.hit = HIT_IDX_W'(i);
        return a;
      end
    end
    return a;
  endfunction

  task automatic flag(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      win_lo = '{default: '0};
      win_hi = '{default: '0};
      box_limit = '0;
      hit_answers.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GMIN_X:    win_lo[0] = cfg_wdata;
          CFG_GMIN_Y:    win_lo[1] = cfg_wdata;
          CFG_GMIN_Z:    win_lo[2] = cfg_wdata;
          CFG_GMAX_X:    win_hi[0] = cfg_wdata;
          CFG_GMAX_Y:    win_hi[1] = cfg_wdata;
          CFG_GMAX_Z:    win_hi[2] = cfg_wdata;
          CFG_BOX_COUNT: box_limit = cfg_wdata[BOX_CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        if (in_bus.req_type == REQ_LOAD) begin
          if (in_bus.box_index < MAX_BOXES) begin
            box_mirror[in_bus.box_index] = '{x_min: in_bus.box_x_min, x_max: in_bus.box_x_max,
                                             y_min: in_bus.box_y_min, y_max: in_bus.box_y_max,
                                             z_min: in_bus.box_z_min, z_max: in_bus.box_z_max};
          end
        end else begin
          hit_answers.insert(hit_answers.size(),
                             first_hit(in_bus.point_x, in_bus.point_y, in_bus.point_z));
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        if (hit_answers.size() == 0) begin
          flag($sformatf("result beat with no query waiting: inside %0d hit %0d outside %0d",
                         out_bus.inside_res, out_bus.hit_index, out_bus.outside_global));
        end else begin
          want = hit_answers.pop_front();
          if (out_bus.inside_res !== want.in_box)
            flag($sformatf("point (%0d,%0d,%0d) inside_res exp %0d got %0d",
                           want.px, want.py, want.pz, want.in_box, out_bus.inside_res));
          if (out_bus.hit_index !== want.hit)
            flag($sformatf("point (%0d,%0d,%0d) hit_index exp %0d got %0d",
                           want.px, want.py, want.pz, want.hit, out_bus.hit_index));
          if (out_bus.outside_global !== want.outside)
            flag($sformatf("point (%0d,%0d,%0d) outside_global exp %0d got %0d",
                           want.px, want.py, want.pz, want.outside, out_bus.outside_global));
        end
      end
    end
    answers_due = hit_answers.size();
  end

endmodule

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pbl_pkg::*;

  localparam int MAX_BOXES = 4096;
  localparam coord_t COORD_MIN = 32'sh8000_0000;
  localparam coord_t COORD_MAX = 32'sh7fff_ffff;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    answers_due;
  bit                    sender_gaps;
  bit                    sink_stalls;
  int                    ready_hold = 0;
  box_t                  shadow [MAX_BOXES];
  bit                    loaded [MAX_BOXES];
  int                    prefix;

  pbl_in_if  in_bus ();
  pbl_out_if out_bus ();

  point_in_box_list_test #(.MAX_BOXES(MAX_BOXES)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  box_hit_checker #(.MAX_BOXES(MAX_BOXES)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .answers_due (answers_due)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_bus.ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
      ready_hold <= $urandom_range(0, 13);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  initial begin
    #3_000_000;
    $display("point_in_box_list_test verification failed");
    $finish;
  end

  function automatic box_t mk_box(coord_t xl, coord_t xh, coord_t yl, coord_t yh,
                                  coord_t zl, coord_t zh);
    return '{x_min: xl, x_max: xh, y_min: yl, y_max: yh, z_min: zl, z_max: zh};
  endfunction

  function automatic box_t full_box();
    return mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
  endfunction

  function automatic coord_t any_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2, 3:    return coord_t'($urandom_range(0, 4000)) - 2000;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // mostly sorted ranges, some narrow, a few inverted
  function automatic box_t rand_box();
    coord_t lo [3];
    coord_t hi [3];
    coord_t a;
    coord_t c;
    for (int k = 0; k < 3; k++) begin
      a = any_coord();
      if ($urandom_range(0, 1) == 1) begin
        c = (a > COORD_MAX - 1000) ? COORD_MAX : a + coord_t'($urandom_range(0, 1000));
      end else begin
        c = any_coord();
        if (c < a && $urandom_range(0, 7) != 0) begin
          lo[k] = c;
          c = a;
          a = lo[k];
        end
      end
      lo[k] = a;
      hi[k] = c;
    end
    return mk_box(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
  endfunction

  // a coordinate on, just past or inside the range; any coordinate when the range is inverted
  function automatic coord_t axis_near(coord_t lo, coord_t hi);
    longint span;
    if (lo > hi) return any_coord();
    span = longint'(hi) - longint'(lo);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      2:       return (lo == COORD_MIN) ? lo : lo - 1;
      3:       return (hi == COORD_MAX) ? hi : hi + 1;
      default: return coord_t'(longint'(lo) + longint'({$urandom}) % (span + 1));
    endcase
  endfunction

  task automatic drive_beat(input logic kind, input logic [BOX_IDX_W-1:0] idx, input box_t b,
                            input coord_t px, input coord_t py, input coord_t pz);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.req_type  <= kind;
    in_bus.box_index <= idx;
    in_bus.box_x_min <= b.x_min;
    in_bus.box_x_max <= b.x_max;
    in_bus.box_y_min <= b.y_min;
    in_bus.box_y_max <= b.y_max;
    in_bus.box_z_min <= b.z_min;
    in_bus.box_z_max <= b.z_max;
    in_bus.point_x   <= px;
    in_bus.point_y   <= py;
    in_bus.point_z   <= pz;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic send_load(input int idx, input box_t b);
    drive_beat(REQ_LOAD, BOX_IDX_W'(idx), b, any_coord(), any_coord(), any_coord());
    shadow[idx] = b;
    loaded[idx] = 1'b1;
    while (prefix < MAX_BOXES && loaded[prefix]) prefix++;
  endtask

  task automatic send_query(input coord_t px, input coord_t py, input coord_t pz);
    drive_beat(REQ_QUERY, BOX_IDX_W'($urandom_range(0, MAX_BOXES - 1)), rand_box(), px, py, pz);
  endtask

  // drop valid, wait for every pending answer, then give a trailing load time to be written
  task automatic settle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (answers_due != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input box_t w);
    write_reg(CFG_GMIN_X, w.x_min);
    write_reg(CFG_GMIN_Y, w.y_min);
    write_reg(CFG_GMIN_Z, w.z_min);
    write_reg(CFG_GMAX_X, w.x_max);
    write_reg(CFG_GMAX_Y, w.y_max);
    write_reg(CFG_GMAX_Z, w.z_max);
  endtask

  // count never exceeds the loaded prefix, so no unwritten slot is scanned
  task automatic run_round(input int items, input int count_cap);
    box_t b;
    int   n;
    int   k;
    settle();
    set_window(($urandom_range(0, 2) != 0) ? full_box() : rand_box());
    n = (prefix < count_cap) ? prefix : count_cap;
    case ($urandom_range(0, 3))
      0: n = 0;
      1: ;
      default: if (n > 0) n = $urandom_range(1, n);
    endcase
    write_reg(CFG_BOX_COUNT, n);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, $urandom);
    repeat (items) begin
      if ($urandom_range(0, 19) == 0) settle();
      if ($urandom_range(0, 9) < 4) begin
        if ($urandom_range(0, 9) < 6)
          k = $urandom_range(0, (prefix < MAX_BOXES - 1) ? prefix + 1 : MAX_BOXES - 1);
        else
          k = $urandom_range(0, MAX_BOXES - 1);
        send_load(k, rand_box());
      end else if (n > 0 && $urandom_range(0, 9) < 7) begin
        b = shadow[$urandom_range(0, n - 1)];
        send_query(axis_near(b.x_min, b.x_max), axis_near(b.y_min, b.y_max),
                   axis_near(b.z_min, b.z_max));
      end else begin
        send_query(any_coord(), any_coord(), any_coord());
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_GMIN_X;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.req_type  <= REQ_LOAD;
    in_bus.box_index <= '0;
    in_bus.box_x_min <= '0;
    in_bus.box_x_max <= '0;
    in_bus.box_y_min <= '0;
    in_bus.box_y_max <= '0;
    in_bus.box_z_min <= '0;
    in_bus.box_z_max <= '0;
    in_bus.point_x   <= '0;
    in_bus.point_y   <= '0;
    in_bus.point_z   <= '0;
    prefix = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;

    // reset window is the single point at the origin, no boxes counted
    send_query(0, 0, 0);
    send_query(1, 0, 0);
    settle();
    set_window(full_box());
    write_reg(CFG_BOX_COUNT, 0);
    send_query(COORD_MIN, COORD_MAX, 0);

    send_load(0, mk_box(10, 5, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    send_load(1, mk_box(100, 100, -100, -100, 7, 7));
    send_load(2, mk_box(COORD_MIN, COORD_MIN + 10, COORD_MAX - 10, COORD_MAX, -5, 5));
    send_load(3, full_box());
    send_load(MAX_BOXES - 1, mk_box(-1, 1, -1, 1, -1, 1));
    settle();
    write_reg(CFG_BOX_COUNT, 4);
    send_query(7, 0, 0);
    send_query(100, -100, 7);
    send_query(100, -100, 8);
    send_query(COORD_MIN, COORD_MAX, -5);
    send_query(COORD_MIN + 11, COORD_MAX, 5);

    // inclusive window edges and one step past each face, then an inverted window and a count of 1
    settle();
    set_window(mk_box(-10, 10, -20, 20, -30, 30));
    write_reg(CFG_SPARE, 32'hffff_ffff);
    send_query(-10, -20, -30);
    send_query(10, 20, 30);
    send_query(-11, 0, 0);
    send_query(11, 0, 0);
    send_query(0, -21, 0);
    send_query(0, 21, 0);
    send_query(0, 0, -31);
    send_query(0, 0, 31);
    settle();
    set_window(mk_box(-1, 1, 5, -5, -1, 1));
    send_query(0, 0, 0);
    settle();
    set_window(full_box());
    write_reg(CFG_BOX_COUNT, 1);
    send_query(7, 0, 0);

    repeat (5) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      run_round(16, 64);
    end

    // saturating counts, every query stops at a hit among the loaded slots
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    settle();
    for (int i = 0; i < 8; i++) send_load(i, mk_box(i * 16, i * 16 + 7, -8, 8, -8, 8));
    settle();
    set_window(full_box());
    write_reg(CFG_BOX_COUNT, MAX_BOXES);
    send_query(7 * 16 + 7, 8, -8);
    send_query(0, 0, 0);
    send_query(3 * 16 + 3, -8, 8);
    settle();
    write_reg(CFG_BOX_COUNT, 8191);
    send_query(6 * 16, 0, 0);
    settle();
    write_reg(CFG_BOX_COUNT, MAX_BOXES + 1);
    send_query(5 * 16 + 2, 1, -1);

    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    run_round(24, 48);
    settle();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && answers_due == 0) begin
      $display("point_in_box_list_test verification clean");
    end else begin
      $display("point_in_box_list_test verification failed");
    end
    $finish;
  end

endmodule
